// ----- rtl/ppcm_pkg.sv -----
package ppcm_pkg;

  // Matrix dimension and the widths that follow from it
  localparam int MAX_LABELS = 32;
  localparam int LBL_W      = $clog2(MAX_LABELS);
  localparam int CNT_W      = $clog2(MAX_LABELS + 1);
  localparam int ADDR_W     = 2 * LBL_W;
  localparam int COEF_DEPTH = MAX_LABELS * MAX_LABELS;

  // Fixed field widths
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 38;
  localparam int CFG_W  = 6;
  localparam int FRAC_W = 14;

  // Input word kinds carried on tuser
  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_SCORE = 1'b1;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Coefficient memory write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    val_t              data;
  } coef_wr_t;

  // Coefficient memory read request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } coef_rd_t;

endpackage

// ----- rtl/ppcm_cell.sv -----
module ppcm_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  ppcm_pkg::acc_t nb_in,
  output ppcm_pkg::acc_t acc_o
);
  import ppcm_pkg::*;

  acc_t acc_r;

  // Take the neighbor's accumulator on every ring step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (shift_en) begin
      acc_r <= nb_in;
    end
  end

  assign acc_o = acc_r;

endmodule

// ----- rtl/ppcm_coef_mem.sv -----
module ppcm_coef_mem (
  input  logic              clk,
  input  ppcm_pkg::coef_wr_t wr,
  input  ppcm_pkg::coef_rd_t rd,
  output ppcm_pkg::val_t     rd_data
);
  import ppcm_pkg::*;

  val_t mem_r [COEF_DEPTH];
  val_t rd_data_r;

  // Write one coefficient
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/per_pixel_class_matrix_mix_core.sv -----
// Per-pixel class mixing: multiplies each pixel's class score vector by a
// 32x32 similarity matrix held in an internal coefficient memory.
// Input stream: tuser selects the word kind (0 coefficient write, 1 score).
// A coefficient word is stored and gives no output. Score words
// come in class order, label_count of them per pixel.
// A score word keeps the input blocked until its ring pass is done, so the
// block takes no new word while a score is applied: the accumulators sit
// in a ring of 32 cells that rotates once per score, one class per cycle
// past a single multiply-accumulate fed by the coefficient memory read port
// through read and multiply stages. The block takes one word at a time.
// After the last score of a pixel the ring rotates once more, emitting
// label_count results (class order, tlast on the final one) and clearing
// every accumulator; the rotation waits while the receiver stalls.
// A single output register holds a result while the receiver stalls; the
// ring waits on it, and the next input word may be taken while the last
// result is still waiting.
// The cfg channel is always ready; write it only while the block is idle.
// Reset clears the accumulators and score index and sets label_count to 32;
// coefficients are undefined until written.
module per_pixel_class_matrix_mix_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // cfg: label_count
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ppcm_pkg::CFG_W-1:0] cfg_data,
  // in_tdata: row [4:0], col [9:5], value [25:10], zero [31:26]
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,
  input  logic                      in_tuser,   // req_type
  // out_tdata: weighted_score [15:0], class_index [20:16], zero [23:21]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,
  output logic                      out_tlast,  // last_of_pixel
  output logic                      out_tuser   // saturated
);
  import ppcm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_EMIT} state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  cfg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LBL_W-1:0]  ec_r;
  logic [LBL_W-1:0]  s_r;
  logic              last_r;
  val_t              score_r;
  logic              rd_vld_r;
  logic [LBL_W-1:0]  rd_z_r;
  logic              prod_vld_r;
  logic [LBL_W-1:0]  prod_z_r;
  prod_t             prod_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_score_r;
  logic [LBL_W-1:0]  out_idx_r;
  logic              out_last_r;
  logic              out_sat_r;

  logic [CNT_W-1:0]  n_act;
  logic [LBL_W-1:0]  n_m1;
  logic [LBL_W-1:0]  s_sel;
  logic              in_acc;
  logic [LBL_W-1:0]  in_row;
  logic [LBL_W-1:0]  in_col;
  val_t              in_val;
  coef_wr_t          mem_wr;
  coef_rd_t          mem_rd;
  val_t              mem_rd_data;
  logic [LBL_W-1:0]  emit_z;
  logic              emit_want;
  logic              emit_step;
  logic              mac_done;
  logic              shift_en;
  acc_t              head;
  acc_t              addend;
  acc_t              fb;
  acc_t              ring [MAX_LABELS];
  logic signed [ACC_W:0]        rnd_q;
  logic signed [ACC_W-FRAC_W:0] rnd_r;
  logic [VAL_W-1:0]  sat_val;
  logic              sat_flag;

  // Unpack the input word
  assign in_row = in_tdata[LBL_W-1:0];
  assign in_col = in_tdata[2*LBL_W-1:LBL_W];
  assign in_val = val_t'(in_tdata[2*LBL_W+VAL_W-1:2*LBL_W]);

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Clamp label_count to 1..MAX_LABELS
  always_comb begin
    priority if (cfg_r == '0) begin
      n_act = CNT_W'(1);
    end else if (CNT_W'(cfg_r) > CNT_W'(MAX_LABELS)) begin
      n_act = CNT_W'(MAX_LABELS);
    end else begin
      n_act = CNT_W'(cfg_r);
    end
  end
  assign n_m1  = LBL_W'(n_act - CNT_W'(1));
  assign s_sel = (ec_r >= n_m1) ? n_m1 : ec_r;

  // Coefficient memory: write in idle, read one row entry per MAC cycle
  assign mem_wr.en   = in_acc && (in_tuser == REQ_COEF);
  assign mem_wr.addr = {in_row, in_col};
  assign mem_wr.data = in_val;
  assign mem_rd.en   = (state_r == S_MAC) && (cnt_r < CNT_W'(MAX_LABELS));
  assign mem_rd.addr = {cnt_r[LBL_W-1:0], s_r};

  ppcm_coef_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  // Ring of accumulator cells; head is cell 0, feedback enters the tail
  assign head = ring[0];

  generate
    for (genvar i = 0; i < MAX_LABELS; i++) begin : g_cell
      acc_t nb;
      if (i == MAX_LABELS - 1) begin : g_tail
        assign nb = fb;
      end else begin : g_mid
        assign nb = ring[i+1];
      end
      ppcm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .nb_in    (nb),
        .acc_o    (ring[i])
      );
    end
  endgenerate

  // Feedback: add the product during MAC, clear during emit
  assign addend = ({1'b0, prod_z_r} < n_act) ? acc_t'(prod_r) : '0;
  assign fb     = (state_r == S_MAC) ? head + addend : '0;

  assign mac_done = prod_vld_r && (prod_z_r == LBL_W'(MAX_LABELS - 1));

  // Emit sequencing: skip classes beyond label_count, wait on the receiver
  assign emit_z    = cnt_r[LBL_W-1:0];
  assign emit_want = ({1'b0, emit_z} < n_act);
  assign emit_step = (state_r == S_EMIT) &&
                     (!emit_want || !out_valid_r || out_tready);
  assign shift_en  = ((state_r == S_MAC) && prod_vld_r) || emit_step;

  // Round half up to Q2.14 and saturate
  assign rnd_q = {head[ACC_W-1], head} + (ACC_W+1)'(1 << (FRAC_W - 1));
  assign rnd_r = rnd_q[ACC_W:FRAC_W];
  always_comb begin
    priority if (rnd_r > (ACC_W-FRAC_W+1)'(32767)) begin
      sat_val  = 16'h7fff;
      sat_flag = 1'b1;
    end else if (rnd_r < -(ACC_W-FRAC_W+1)'(32768)) begin
      sat_val  = 16'h8000;
      sat_flag = 1'b1;
    end else begin
      sat_val  = rnd_r[VAL_W-1:0];
      sat_flag = 1'b0;
    end
  end

  // Read and multiply stages
  always_ff @(posedge clk) begin
    prod_z_r <= rd_z_r;
    rd_z_r   <= cnt_r[LBL_W-1:0];
    if (rd_vld_r) begin
      prod_r <= score_r * mem_rd_data;
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(MAX_LABELS);
      cnt_r       <= '0;
      ec_r        <= '0;
      s_r         <= '0;
      last_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      rd_vld_r   <= mem_rd.en;
      prod_vld_r <= rd_vld_r;

      // Drop a taken word, load a new one
      if (emit_step && emit_want) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == REQ_SCORE)) begin
            score_r <= in_val;
            s_r     <= s_sel;
            last_r  <= (s_sel == n_m1);
            ec_r    <= (s_sel == n_m1) ? '0 : s_sel + LBL_W'(1);
            cnt_r   <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (mem_rd.en) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (mac_done) begin
            cnt_r   <= '0;
            state_r <= last_r ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_step) begin
            cnt_r <= cnt_r + CNT_W'(1);
            if (emit_z == LBL_W'(MAX_LABELS - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit_step && emit_want) begin
      out_score_r <= sat_val;
      out_idx_r   <= emit_z;
      out_last_r  <= (emit_z == n_m1);
      out_sat_r   <= sat_flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_idx_r, out_score_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_sat_r;

endmodule

// ----- bench/class_mix_monitor.sv -----
module class_mix_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [ppcm_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [31:0]                in_tdata,
  input  logic                       in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [23:0]                out_tdata,
  input  logic                       out_tlast,
  input  logic                       out_tuser,
  output int                         mismatches,
  output int                         waiting
);

  import ppcm_pkg::*;

  typedef struct packed {
    val_t       score;
    logic [4:0] cls;
    logic       last;
    logic       sat;
  } mix_result_t;

  // Shadow copy of the block state
  val_t             coef_mem [0:MAX_LABELS-1][0:MAX_LABELS-1];
  acc_t             class_acc [0:MAX_LABELS-1];
  logic [LBL_W-1:0] score_idx;
  logic [CFG_W-1:0] label_reg;
  mix_result_t      owed_results [$];

  // Clamp the programmed class count to the usable range
  function automatic int unsigned labels_in_use();
    if (label_reg == 0) return 1;
    if (label_reg > MAX_LABELS) return MAX_LABELS;
    return label_reg;
  endfunction

  // Apply one input word: store a coefficient or accumulate a score
  function automatic void absorb_word(input logic kind, input logic [31:0] word);
    logic [4:0]  r;
    logic [4:0]  c;
    val_t        v;
    int unsigned n;
    int unsigned s;
    prod_t       prod;
    acc_t        rounded;
    mix_result_t res;
    r = word[4:0];
    c = word[9:5];
    v = word[25:10];
    if (kind == REQ_COEF) begin
      coef_mem[r][c] = v;
      return;
    end
    n = labels_in_use();
    s = score_idx;
    if (s >= n) s = n - 1;
    for (int z = 0; z < n; z++) begin
      prod = v * coef_mem[z][s];
      class_acc[z] = class_acc[z] + prod;
    end
    if (s + 1 < n) begin
      score_idx = LBL_W'(s + 1);
      return;
    end
    // Pixel complete: round half up, clip, and queue one result per class
    for (int z = 0; z < n; z++) begin
      rounded = (class_acc[z] + acc_t'(8192)) >>> FRAC_W;
      res.score = rounded[VAL_W-1:0];
      res.sat = 1'b0;
      if (rounded > 32767) begin
        res.score = 16'sh7fff;
        res.sat = 1'b1;
      end else if (rounded < -32768) begin
        res.score = 16'sh8000;
        res.sat = 1'b1;
      end
      res.cls = z[4:0];
      res.last = (z == n - 1);
      owed_results.push_back(res);
    end
    for (int z = 0; z < MAX_LABELS; z++) class_acc[z] = '0;
    score_idx = '0;
  endfunction

  always @(posedge clk) begin
    mix_result_t got;
    mix_result_t want;
    if (!rst_n) begin
      for (int z = 0; z < MAX_LABELS; z++) class_acc[z] = '0;
      score_idx = '0;
      label_reg = CFG_W'(MAX_LABELS);
      owed_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) label_reg = cfg_data;
      if (in_tvalid && in_tready) absorb_word(in_tuser, in_tdata);
      // Compare each delivered word with the oldest owed result
      if (out_tvalid && out_tready) begin
        got.score = out_tdata[15:0];
        got.cls = out_tdata[20:16];
        got.last = out_tlast;
        got.sat = out_tuser;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: score %0d class %0d last %0b sat %0b",
                     $signed(got.score), got.cls, got.last, got.sat);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mix mismatch: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                       $signed(want.score), want.cls, want.last, want.sat,
                       $signed(got.score), got.cls, got.last, got.sat);
          end
        end
      end
    end
    waiting = owed_results.size();
  end

endmodule

// ----- bench/per_pixel_class_matrix_mix_core_test.sv -----
module per_pixel_class_matrix_mix_core_test;

  import ppcm_pkg::*;

  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 420;
  localparam int CALM_AFTER     = 360;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;   // row [4:0], col [9:5], value [25:10], zero [31:26]
  logic                 in_tuser = 1'b0; // req_type
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;       // weighted_score [15:0], class_index [20:16], zero [23:21]
  logic                 out_tlast;       // last_of_pixel
  logic                 out_tuser;       // saturated

  int mismatches;
  int waiting;
  int quiet = 0;
  int stall_left = 0;
  int gap_odds = 5;
  bit calm = 1'b0;
  int active_n = MAX_LABELS;
  bit coef_set [0:MAX_LABELS-1][0:MAX_LABELS-1];

  per_pixel_class_matrix_mix_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  class_mix_monitor mix_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .mismatches(mismatches), .waiting(waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abort when no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Mix of extremes, small values and full-range values
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = 16'h0000;
      3, 4, 5: begin
        v = 16'($urandom_range(0, 4095));
        v = v - 16'd2048;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic hold_gap();
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic kind, input logic [4:0] r, input logic [4:0] c,
                           input logic [15:0] v);
    hold_gap();
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b0, v, c, r};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_coef(input logic [4:0] r, input logic [4:0] c, input logic [15:0] v);
    send_word(REQ_COEF, r, c, v);
    coef_set[r][c] = 1'b1;
  endtask

  task automatic send_score(input logic [15:0] v);
    send_word(REQ_SCORE, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), v);
  endtask

  // Hold off input until all results are in and the block has gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_labels(input logic [CFG_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_n = (v == 0) ? 1 : (v > MAX_LABELS) ? MAX_LABELS : v;
  endtask

  // Write every coefficient the active classes can read that is still unset
  task automatic fill_matrix();
    for (int r = 0; r < active_n; r++)
      for (int c = 0; c < active_n; c++)
        if (!coef_set[r][c]) write_coef(5'(r), 5'(c), pick_value());
  endtask

  initial begin
    int               random_count;
    int               phase;
    int               span;
    logic [CFG_W-1:0] lbl;
    random_count = 0;
    phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single class (zero count), extreme products, rounding ties
    set_labels(6'd0);
    write_coef(5'd0, 5'd0, 16'h7fff);
    send_score(16'h7fff);
    send_score(16'h8000);
    write_coef(5'd0, 5'd0, 16'h8000);
    send_score(16'h8000);
    write_coef(5'd0, 5'd0, 16'd8192);
    send_score(16'd1);
    send_score(16'hffff);
    send_score(16'd0);
    // Coefficients outside the active classes
    write_coef(5'd31, 5'd31, 16'h8000);
    write_coef(5'd5, 5'd20, 16'h7fff);

    // Count changed within a pixel, upward then downward, with a write inside
    set_labels(6'd3);
    fill_matrix();
    send_score(pick_value());
    write_coef(5'd2, 5'd1, 16'h4000);
    send_score(pick_value());
    set_labels(6'd8);
    fill_matrix();
    send_score(pick_value());
    set_labels(6'd2);
    send_score(pick_value());

    // Random phases, each under its own class count
    while (random_count < RANDOM_WORDS) begin
      case (phase)
        0: lbl = 6'd63;
        1: lbl = 6'd33;
        2: lbl = 6'd32;
        default: begin
          case ($urandom_range(0, 19))
            0, 1, 2: lbl = 6'd0;
            3, 4, 5: lbl = 6'($urandom_range(9, 32));
            6: lbl = 6'($urandom_range(33, 63));
            default: lbl = 6'($urandom_range(1, 8));
          endcase
        end
      endcase
      set_labels(lbl);
      fill_matrix();
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      span = $urandom_range(20, 40);
      for (int k = 0; k < span && random_count < RANDOM_WORDS; k++) begin
        if (random_count >= CALM_AFTER) calm = 1'b1;
        if ($urandom_range(0, 6) == 0)
          write_coef(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), pick_value());
        else
          send_score(pick_value());
        random_count++;
      end
      phase++;
    end

    drain();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
